@@ hdl/tope_pkg.sv @@
// ----------------------------------------------------------------------------
// tope_pkg
// shared constants and types of the topological order engine
// ----------------------------------------------------------------------------
package tope_pkg;
	localparam int MaxVertices = 32;
	localparam int MaxEdges    = 256;
	localparam int VW = 5;
	localparam int EAW = $clog2(MaxEdges);
	localparam int ECW = EAW + 1;
	localparam int QCW = $clog2(MaxVertices) + 1;

	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_ACYCLIC = 2'd1;
	localparam logic [1:0] KIND_CYCLE = 2'd2;

	typedef struct packed {
		logic [VW-1:0] src;
		logic [VW-1:0] dst;
	} edge_t;
endpackage

@@ hdl/tope_edge_ram.sv @@
// ----------------------------------------------------------------------------
// tope_edge_ram
// edge store, one write and one registered read port
// ----------------------------------------------------------------------------
module tope_edge_ram import tope_pkg::*; (
	input  logic               clk,
	input  logic               we,
	input  logic [EAW-1:0]     waddr,
	input  edge_t              wdata,
	input  logic [EAW-1:0]     raddr,
	output edge_t              rdata
);
	edge_t mem_q [MaxEdges];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/topological_order_engine.sv @@
// ----------------------------------------------------------------------------
// topological_order_engine
// kahn topological sort over a loaded edge list
// ----------------------------------------------------------------------------
// channel   dir  content
// s_axis    in   edges, tlast starts the sort
// m_axis    out  vertices in order, then a closing status item
// cfg       in   num_vertices
// loading is held while a result is pending. a sort counts in-degrees, seeds
// the queue, and per popped vertex scans the edge store through its single
// read port; output stalls hold the sort as well.
// s_axis_tready is low during the sort. reset clears control state only.
module topological_order_engine import tope_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // edge_from[4:0], edge_to[9:5], edge_present[10]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // vertex_out[4:0], edges_dropped[5]
	output logic [1:0]  m_axis_tuser,  // result_kind[1:0]
	output logic        m_axis_tlast,  // run_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);
	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_CNT   = 7'b0000010,
		ST_SEED  = 7'b0000100,
		ST_POP   = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_CLOSE = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t st_q, ret_q;
	logic [5:0] nv_q;
	logic [ECW-1:0] etot_q, ei_q;
	logic ovf_q, rd_ph_q;
	logic [8:0] indeg_q [MaxVertices];
	logic [VW-1:0] queue_q [MaxVertices];
	logic [QCW-1:0] head_q, tail_q, emitted_q;
	logic [VW-1:0] cur_q;
	logic [QCW-1:0] vi_q;
	logic ovalid_q, olast_q, odrop_q;
	logic [VW-1:0] ovtx_q;
	logic [1:0] okind_q;
	edge_t rd_e;
	edge_t wr_e;
	logic [EAW-1:0] raddr;
	logic [QCW-1:0] n_eff;
	logic s_fire, in_ok;
	logic [VW-1:0] e_from, e_to;

	assign n_eff = (nv_q == 6'd0) ? QCW'(1) :
		(nv_q > 6'(MaxVertices)) ? QCW'(MaxVertices) : QCW'(nv_q);
	assign e_from = s_axis_tdata[4:0];
	assign e_to = s_axis_tdata[9:5];
	assign s_axis_tready = (st_q == ST_LOAD) && !ovalid_q;
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign in_ok = s_axis_tdata[10] && (QCW'(e_from) < n_eff) && (QCW'(e_to) < n_eff)
		&& (etot_q < ECW'(MaxEdges));
	assign raddr = (st_q == ST_CNT) ? ei_q[EAW-1:0] : EAW'(ei_q - ECW'(1));
	assign wr_e.src = e_from;
	assign wr_e.dst = e_to;

	tope_edge_ram u_ram (
		.clk(clk), .we(s_fire && in_ok), .waddr(etot_q[EAW-1:0]),
		.wdata(wr_e), .raddr(raddr), .rdata(rd_e)
	);

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {2'b00, odrop_q, ovtx_q};
	assign m_axis_tuser = okind_q;
	assign m_axis_tlast = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD; ret_q <= ST_LOAD; nv_q <= 6'd32; etot_q <= '0;
			ovf_q <= 1'b0; ei_q <= '0; rd_ph_q <= 1'b0; head_q <= '0; tail_q <= '0;
			emitted_q <= '0; vi_q <= '0; ovalid_q <= 1'b0; cur_q <= '0;
			ovtx_q <= '0; okind_q <= KIND_VERTEX; odrop_q <= 1'b0; olast_q <= 1'b0;
		end else begin
			if (cfg_valid) nv_q <= cfg_data;
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			case (st_q)
				ST_LOAD: begin
					if (s_fire) begin
						if (s_axis_tdata[10]) begin
							if (in_ok) etot_q <= etot_q + ECW'(1);
							else ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							st_q <= ST_CNT; ei_q <= '0; rd_ph_q <= 1'b0;
							for (int i = 0; i < MaxVertices; i++) indeg_q[i] <= '0;
						end
					end
				end
				ST_CNT: begin
					// count in-degrees, read issued then used next cycle
					if (!rd_ph_q) begin
						if (ei_q == etot_q) begin
							st_q <= ST_SEED; vi_q <= '0; head_q <= '0; tail_q <= '0;
							emitted_q <= '0;
						end else rd_ph_q <= 1'b1;
					end else begin
						rd_ph_q <= 1'b0; ei_q <= ei_q + ECW'(1);
						if (QCW'(rd_e.src) >= n_eff || QCW'(rd_e.dst) >= n_eff) ovf_q <= 1'b1;
						else indeg_q[rd_e.dst] <= indeg_q[rd_e.dst] + 9'd1;
					end
				end
				ST_SEED: begin
					if (vi_q == n_eff) st_q <= ST_POP;
					else begin
						if (indeg_q[vi_q[VW-1:0]] == 9'd0) begin
							queue_q[tail_q[VW-1:0]] <= vi_q[VW-1:0];
							tail_q <= tail_q + QCW'(1);
						end
						vi_q <= vi_q + QCW'(1);
					end
				end
				ST_POP: begin
					if (head_q == tail_q) st_q <= ST_CLOSE;
					else if (!ovalid_q) begin
						cur_q <= queue_q[head_q[VW-1:0]];
						ovalid_q <= 1'b1; ovtx_q <= queue_q[head_q[VW-1:0]];
						okind_q <= KIND_VERTEX; odrop_q <= 1'b0; olast_q <= 1'b0;
						head_q <= head_q + QCW'(1); emitted_q <= emitted_q + QCW'(1);
						ei_q <= etot_q; rd_ph_q <= 1'b0; st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// newest edge first
					if (!rd_ph_q) begin
						if (ei_q == '0) st_q <= ST_POP;
						else rd_ph_q <= 1'b1;
					end else begin
						rd_ph_q <= 1'b0; ei_q <= ei_q - ECW'(1);
						if (rd_e.src == cur_q && QCW'(rd_e.dst) < n_eff
								&& indeg_q[rd_e.dst] != 9'd0) begin
							indeg_q[rd_e.dst] <= indeg_q[rd_e.dst] - 9'd1;
							if (indeg_q[rd_e.dst] == 9'd1 && tail_q < QCW'(MaxVertices)) begin
								queue_q[tail_q[VW-1:0]] <= rd_e.dst;
								tail_q <= tail_q + QCW'(1);
							end
						end
					end
				end
				ST_CLOSE: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1; ovtx_q <= '0;
						okind_q <= (emitted_q == n_eff) ? KIND_ACYCLIC : KIND_CYCLE;
						odrop_q <= ovf_q; olast_q <= 1'b1;
						etot_q <= '0; ovf_q <= 1'b0; st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					ret_q <= ST_LOAD;
					st_q <= ret_q;
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) (st_q != ST_LOAD) |-> !s_axis_tready)
		else $error("ready outside load");
	assert property (@(posedge clk) disable iff (!arst_n) head_q <= tail_q)
		else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n) tail_q <= QCW'(MaxVertices))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !m_axis_tready) |=> ovalid_q) else $error("result lost");
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the topological order engine: edge streams are
// driven with random gaps, every graph is sorted by a local kahn predictor and
// each output transfer is compared with the oldest predicted result
// ----------------------------------------------------------------------------
module tb_top;
	import tope_pkg::*;

	typedef struct packed {
		logic [4:0] vertex;
		logic [1:0] kind;
		logic       dropped;
		logic       closing;
	} order_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;

	topological_order_engine uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [5:0]  vertex_count = 6'd32;
	logic [4:0]  graph_src [MaxEdges];
	logic [4:0]  graph_dst [MaxEdges];
	int          graph_edges = 0;
	bit          graph_dropped = 0;
	order_item_t pending_order [$];

	int  mismatches = 0;
	int  idle_cycles = 0;
	bit  quiet = 0;
	int  sink_stall = 0;

	function automatic int active_vertices();
		int n;
		n = vertex_count;
		if (n == 0) n = 1;
		if (n > MaxVertices) n = MaxVertices;
		return n;
	endfunction

	// kahn sort of the collected graph, pushes the predicted output sequence
	function automatic void predict_order();
		int n, head, tail, emitted, s, d;
		int indeg [MaxVertices];
		int fifo [MaxVertices];
		order_item_t r;
		n = active_vertices();
		head = 0;
		tail = 0;
		emitted = 0;
		foreach (indeg[i]) indeg[i] = 0;
		for (int e = 0; e < graph_edges; e++) begin
			s = graph_src[e];
			d = graph_dst[e];
			if (s >= n || d >= n) graph_dropped = 1;
			else indeg[d]++;
		end
		for (int i = 0; i < n; i++)
			if (indeg[i] == 0) begin
				fifo[tail] = i;
				tail++;
			end
		while (head < tail) begin
			r = '{vertex: 5'(fifo[head]), kind: KIND_VERTEX, dropped: 1'b0, closing: 1'b0};
			pending_order.push_back(r);
			emitted++;
			// newest edge first
			for (int e = graph_edges - 1; e >= 0; e--) begin
				d = graph_dst[e];
				if (graph_src[e] == fifo[head] && d < n && indeg[d] > 0) begin
					indeg[d]--;
					if (indeg[d] == 0 && tail < MaxVertices) begin
						fifo[tail] = d;
						tail++;
					end
				end
			end
			head++;
		end
		r = '{vertex: 5'd0, kind: (emitted == n) ? KIND_ACYCLIC : KIND_CYCLE,
			dropped: graph_dropped, closing: 1'b1};
		pending_order.push_back(r);
		graph_edges = 0;
		graph_dropped = 0;
	endfunction

	function automatic void absorb_edge(logic [4:0] src, logic [4:0] dst, bit present,
			bit last);
		int n;
		n = active_vertices();
		if (present) begin
			if (src >= n || dst >= n || graph_edges >= MaxEdges) graph_dropped = 1;
			else begin
				graph_src[graph_edges] = src;
				graph_dst[graph_edges] = dst;
				graph_edges++;
			end
		end
		if (last) predict_order();
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one edge transfer; valid stays high afterwards unless a gap follows
	task automatic send_edge(logic [4:0] src, logic [4:0] dst, bit present, bit last);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {5'b0, present, dst, src};
		s_axis_tlast = last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		absorb_edge(src, dst, present, last);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_order.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_vertex_count(logic [5:0] value);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		vertex_count = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// output sink with random stalls
	always @(negedge clk) begin
		if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			m_axis_tready <= 1'b0;
		end else begin
			sink_stall <= pick_gap();
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		order_item_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_order.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: vertex %0d kind %0d", m_axis_tdata[4:0],
						m_axis_tuser);
			end else begin
				want = pending_order.pop_front();
				if (m_axis_tdata[4:0] !== want.vertex || m_axis_tuser !== want.kind ||
						m_axis_tdata[5] !== want.dropped || m_axis_tlast !== want.closing ||
						m_axis_tdata[7:6] !== 2'b0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp v=%0d k=%0d d=%0d e=%0d, got v=%0d k=%0d d=%0d e=%0d",
							want.vertex, want.kind, want.dropped, want.closing,
							m_axis_tdata[4:0], m_axis_tuser, m_axis_tdata[5],
							m_axis_tlast);
				end
			end
		end
	end

	// watchdog on transfer activity
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 60000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic test_small_dags();
		// chain, diamond, isolated vertices, parallel edges, empty final item
		set_vertex_count(6'd6);
		send_edge(5'd0, 5'd1, 1, 0);
		send_edge(5'd1, 5'd2, 1, 0);
		send_edge(5'd0, 5'd2, 1, 0);
		send_edge(5'd0, 5'd2, 1, 0);
		send_edge(5'd3, 5'd4, 1, 0);
		send_edge(5'd0, 5'd0, 0, 0);
		send_edge(5'd2, 5'd5, 1, 1);
		send_edge(5'd0, 5'd0, 0, 1);
		send_edge(5'd4, 5'd3, 1, 1);
	endtask

	task automatic test_cycles();
		send_edge(5'd0, 5'd1, 1, 0);
		send_edge(5'd1, 5'd2, 1, 0);
		send_edge(5'd2, 5'd0, 1, 0);
		send_edge(5'd3, 5'd3, 1, 1);
	endtask

	task automatic test_vertex_extremes();
		set_vertex_count(6'd1);
		send_edge(5'd0, 5'd0, 0, 1);
		send_edge(5'd0, 5'd0, 1, 1);
		set_vertex_count(6'd0);
		send_edge(5'd0, 5'd1, 1, 0);
		send_edge(5'd31, 5'd0, 1, 1);
		set_vertex_count(6'd63);
		send_edge(5'd31, 5'd0, 1, 0);
		send_edge(5'd0, 5'd31, 1, 1);
		set_vertex_count(6'd32);
		send_edge(5'd31, 5'd30, 1, 0);
		send_edge(5'd21, 5'd10, 1, 1);
	endtask

	task automatic test_count_lowered();
		// edges stored under 32 vertices, then the count shrinks before the sort
		set_vertex_count(6'd32);
		send_edge(5'd1, 5'd20, 1, 0);
		send_edge(5'd0, 5'd1, 1, 0);
		set_vertex_count(6'd4);
		send_edge(5'd2, 5'd3, 1, 1);
	endtask

	task automatic test_store_full();
		set_vertex_count(6'd32);
		quiet = 1;
		for (int i = 0; i < MaxEdges + 3; i++)
			send_edge(5'($urandom_range(0, 15)), 5'($urandom_range(16, 31)), 1, 0);
		quiet = 0;
		send_edge(5'd0, 5'd31, 1, 1);
		wait_drained();
	endtask

	task automatic test_random_graphs();
		int sent, edges, mode, n;
		logic [4:0] a, b;
		sent = 0;
		while (sent < 180) begin
			if ($urandom_range(0, 3) == 0)
				set_vertex_count($urandom_range(0, 3) == 0 ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(2, 32)));
			quiet = ($urandom_range(0, 5) == 0);
			n = active_vertices();
			edges = $urandom_range(0, 12);
			mode = $urandom_range(0, 9);
			for (int i = 0; i <= edges; i++) begin
				a = 5'($urandom_range(0, n - 1));
				b = 5'($urandom_range(0, n - 1));
				// forward edges keep the graph acyclic, but a self-loop on the last vertex can remain
				if (mode < 6 && a > b) begin
					a ^= b; b ^= a; a ^= b;
				end
				if (mode < 6 && a == b) b = (b == n - 1) ? b : 5'(b + 5'd1);
				if (mode == 9 && $urandom_range(0, 2) == 0) begin
					a = 5'($urandom); b = 5'($urandom);
				end
				send_edge(a, b, $urandom_range(0, 7) != 0, i == edges);
				sent++;
			end
			if ($urandom_range(0, 4) == 0) wait_drained();
		end
		quiet = 0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_small_dags();
		test_cycles();
		test_vertex_extremes();
		test_count_lowered();
		test_store_full();
		test_random_graphs();
		wait_drained();
		repeat (40) @(negedge clk);
		mismatches += pending_order.size();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

@@ sim.f @@
hdl/tope_pkg.sv
hdl/tope_edge_ram.sv
hdl/topological_order_engine.sv
sim/tb_top.sv
